// ----- sv/tbi_pkg.sv -----
// Package for the barycentric inside test: config register map and port widths.
package tbi_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X   = 3'd0,
    REG_A_Y   = 3'd1,
    REG_B_X   = 3'd2,
    REG_B_Y   = 3'd3,
    REG_C_X   = 3'd4,
    REG_C_Y   = 3'd5,
    REG_LIMIT = 3'd6
  } cfg_reg_t;

endpackage

// ----- sv/tbi_pt_if.sv -----
// Input channel interface: one query point per transfer.
interface tbi_pt_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// ----- sv/tbi_res_if.sv -----
// Result channel interface: inside flag, degenerate flag and three weights.
interface tbi_res_if #(parameter int WEIGHT_FRAC_BITS = 16) ();
  logic                                valid;
  logic                                ready;
  logic                                inside_res;
  logic                                degenerate;
  logic signed [WEIGHT_FRAC_BITS+2:0]  weight_u;
  logic signed [WEIGHT_FRAC_BITS+2:0]  weight_v;
  logic signed [WEIGHT_FRAC_BITS+2:0]  weight_w;

  modport source (output valid, inside_res, degenerate, weight_u, weight_v, weight_w,
                  input ready);
  modport sink   (input valid, inside_res, degenerate, weight_u, weight_v, weight_w,
                  output ready);
endinterface

// ----- sv/triangle_barycentric_inside_test.sv -----
// Barycentric point-in-triangle test: pipelined edge functions and weight dividers.
// Pipeline from input transfer to result:
//   four front stages, one restoring divide stage per weight bit, one output stage.
// Throughput: one point per cycle; the three weight dividers are fully pipelined.
// The whole pipeline holds while a finished result waits on out_res.ready.
// Reset (synchronous, rst_n low) clears the valid bits and all config registers to 0.
module triangle_barycentric_inside_test #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tbi_pt_if.sink                          in_pt,
  tbi_res_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [tbi_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tbi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int WF    = WEIGHT_FRAC_BITS;
  localparam int DW    = CW + 1;          // coordinate differences
  localparam int PW    = 2 * DW;          // products
  localparam int NW    = 2 * CW + 5;      // numerators and determinant
  localparam int QB    = WF + 3;          // weight width, quotient bits
  localparam int LW    = tbi_pkg::CFG_DATA_W;
  localparam int CMP_W = (NW > LW) ? NW : LW;

  // Configuration registers
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [LW-1:0]        limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0; cx_r <= '0; cy_r <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        tbi_pkg::REG_A_X:   ax_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_A_Y:   ay_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_B_X:   bx_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_B_Y:   by_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_C_X:   cx_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_C_Y:   cy_r    <= cfg_wdata[CW-1:0];
        tbi_pkg::REG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: whole pipeline moves unless the output holds an untaken result
  logic ce;
  logic out_v_r;
  assign ce           = !out_v_r || out_res.ready;
  assign in_pt.ready  = ce;

  // Valid bits: s1, s2, s3, divider stages 0..QB, output
  logic s1_v_r, s2_v_r, s3_v_r;
  logic dv_r [0:QB];

  // Stage 1: differences
  logic signed [DW-1:0] dx_r, dy_r, e0x_r, e0y_r, e1x_r, e1y_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r  <= DW'(in_pt.point_x) - DW'(ax_r);
      dy_r  <= DW'(in_pt.point_y) - DW'(ay_r);
      e0x_r <= DW'(bx_r) - DW'(ax_r);
      e0y_r <= DW'(by_r) - DW'(ay_r);
      e1x_r <= DW'(cx_r) - DW'(ax_r);
      e1y_r <= DW'(cy_r) - DW'(ay_r);
    end
  end

  // Stage 2: cross products
  logic signed [PW-1:0] m_det0_r, m_det1_r, m_v0_r, m_v1_r, m_w0_r, m_w1_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      m_det0_r <= e0x_r * e1y_r;
      m_det1_r <= e1x_r * e0y_r;
      m_v0_r   <= dx_r * e1y_r;
      m_v1_r   <= e1x_r * dy_r;
      m_w0_r   <= e0x_r * dy_r;
      m_w1_r   <= dx_r * e0y_r;
    end
  end

  // Stage 3: determinant and edge numerators
  logic signed [NW-1:0] det_r, nv_r, nw_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      det_r <= NW'(m_det0_r) - NW'(m_det1_r);
      nv_r  <= NW'(m_v0_r) - NW'(m_v1_r);
      nw_r  <= NW'(m_w0_r) - NW'(m_w1_r);
    end
  end

  // Divider pipeline storage: index k is the state after k quotient bits
  logic [NW-1:0] rem_r [0:QB][0:2];
  logic [QB-1:0] quo_r [0:QB][0:2];
  logic [NW-1:0] an_r  [0:QB][0:2];
  logic          neg_r [0:QB][0:2];
  logic          ovf_r [0:QB][0:2];
  logic [NW-1:0] ad_r  [0:QB];
  logic          ins_r [0:QB];
  logic          deg_r [0:QB];

  // Stage 4: third numerator, containment, degeneracy, magnitudes, divider setup
  logic signed [NW-1:0] nu_c;
  logic signed [NW-1:0] num_c [0:2];
  logic [NW-1:0]        mag_c [0:2];
  logic [NW-1:0]        adet_c;
  logic                 ins_c, deg_c;

  always_comb begin
    nu_c     = det_r - nv_r - nw_r;
    num_c[0] = nu_c;
    num_c[1] = nv_r;
    num_c[2] = nw_r;
    for (int j = 0; j < 3; j++) begin
      mag_c[j] = num_c[j][NW-1] ? NW'(-num_c[j]) : NW'(num_c[j]);
    end
    adet_c = det_r[NW-1] ? NW'(-det_r) : NW'(det_r);
    deg_c  = CMP_W'(adet_c) <= CMP_W'(limit_r);
    if (!det_r[NW-1]) begin
      ins_c = !nu_c[NW-1] && !nv_r[NW-1] && !nw_r[NW-1];
    end else begin
      ins_c = ((nu_c[NW-1]) || (nu_c == '0)) && ((nv_r[NW-1]) || (nv_r == '0)) &&
              ((nw_r[NW-1]) || (nw_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ad_r[0]  <= adet_c;
      ins_r[0] <= ins_c && !deg_c;
      deg_r[0] <= deg_c;
      for (int j = 0; j < 3; j++) begin
        an_r[0][j]  <= mag_c[j];
        neg_r[0][j] <= num_c[j][NW-1] != det_r[NW-1];
        ovf_r[0][j] <= (mag_c[j] >> 3) >= adet_c;
        rem_r[0][j] <= mag_c[j] >> 3;
        quo_r[0][j] <= '0;
      end
    end
  end

  // Restoring divide: one quotient bit per stage, three lanes
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BI = QB - 1 - k;   // dividend bit brought down at this step
    logic [NW:0]   sh_c  [0:2];
    logic [NW:0]   dif_c [0:2];
    logic          ge_c  [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic nb_l;
      if (BI >= WF) begin : g_hi
        assign nb_l = an_r[k][j][BI-WF];
      end else begin : g_lo
        assign nb_l = 1'b0;
      end
      always_comb begin
        sh_c[j]  = {rem_r[k][j], nb_l};
        dif_c[j] = sh_c[j] - {1'b0, ad_r[k]};
        ge_c[j]  = sh_c[j] >= {1'b0, ad_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ad_r[k+1]  <= ad_r[k];
        ins_r[k+1] <= ins_r[k];
        deg_r[k+1] <= deg_r[k];
        for (int j = 0; j < 3; j++) begin
          an_r[k+1][j]  <= an_r[k][j];
          neg_r[k+1][j] <= neg_r[k][j];
          ovf_r[k+1][j] <= ovf_r[k][j];
          rem_r[k+1][j] <= ge_c[j] ? dif_c[j][NW-1:0] : sh_c[j][NW-1:0];
          quo_r[k+1][j] <= {quo_r[k][j][QB-2:0], ge_c[j]};
        end
      end
    end
  end

  // Output stage: sign, saturation, degenerate zeroing
  logic signed [QB-1:0] wt_c [0:2];
  logic                 sat_c [0:2];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat_c[j] = ovf_r[QB][j] || quo_r[QB][j][QB-1];
      if (deg_r[QB]) begin
        wt_c[j] = '0;
      end else if (neg_r[QB][j]) begin
        wt_c[j] = sat_c[j] ? {1'b1, {(QB-1){1'b0}}} : QB'(-quo_r[QB][j]);
      end else begin
        wt_c[j] = sat_c[j] ? {1'b0, {(QB-1){1'b1}}} : quo_r[QB][j];
      end
    end
  end

  logic                 inside_r, degen_r;
  logic signed [QB-1:0] wu_r, wv_r, ww_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      inside_r <= ins_r[QB];
      degen_r  <= deg_r[QB];
      wu_r     <= wt_c[0];
      wv_r     <= wt_c[1];
      ww_r     <= wt_c[2];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= QB; k++) dv_r[k] <= 1'b0;
    end else if (ce) begin
      s1_v_r  <= in_pt.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      dv_r[0] <= s3_v_r;
      for (int k = 0; k < QB; k++) dv_r[k+1] <= dv_r[k];
      out_v_r <= dv_r[QB];
    end
  end

  assign out_res.valid      = out_v_r;
  assign out_res.inside_res = inside_r;
  assign out_res.degenerate = degen_r;
  assign out_res.weight_u   = wu_r;
  assign out_res.weight_v   = wv_r;
  assign out_res.weight_w   = ww_r;

  // Degenerate triangle gives zero weights and an outside point
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && degen_r |-> !inside_r && wu_r == '0 && wv_r == '0 && ww_r == '0)
    else $error("degenerate result with nonzero fields");

  // A point inside the triangle never gets a negative weight
  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && inside_r |-> !wu_r[QB-1] && !wv_r[QB-1] && !ww_r[QB-1])
    else $error("inside point with negative weight");

  // Nothing is offered on the output right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_v_r)
    else $error("result valid right after reset");

  // A stalled pipeline does not change its front stages
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(s1_v_r) && $stable(s3_v_r) && $stable(dv_r[0]))
    else $error("pipeline moved during stall");

endmodule

// ----- bench/triangle_barycentric_inside_test_tb.sv -----
// Testbench for the barycentric point-in-triangle test block.
`timescale 1ns / 100ps

module testbench;

  localparam int CW        = 16;
  localparam int WF        = 16;
  localparam int WW        = WF + 3;
  localparam int LATENCY   = WF + 8;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    bit                   in_tri;
    bit                   degen;
    logic signed [WW-1:0] u;
    logic signed [WW-1:0] v;
    logic signed [WW-1:0] w;
  } weights_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tbi_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tbi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tbi_pt_if  #(.COORD_WIDTH(CW))      pt ();
  tbi_res_if #(.WEIGHT_FRAC_BITS(WF)) res ();

  triangle_barycentric_inside_test #(
    .COORD_WIDTH(CW),
    .WEIGHT_FRAC_BITS(WF)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_pt(pt.sink),
    .out_res(res.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the triangle registers
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic [31:0]          area_limit;

  weights_t pending_weights[$];
  int  error_count;
  int  points_sent;
  int  results_seen;
  int  degen_seen;
  int  inside_seen;
  bit  no_idle;
  bit  hold_request;
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Doubled signed area of the configured triangle
  function automatic longint area2();
    return (longint'(bx) - ax) * (longint'(cy) - ay) - (longint'(cx) - ax) * (longint'(by) - ay);
  endfunction

  // n * 2^WF / d toward zero, saturated to WW bits signed
  function automatic logic signed [WW-1:0] scaled_ratio(longint n, longint d);
    longint an, ad, q, lim;
    bit neg;
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    lim = longint'(1) << (WW - 1);
    q   = an / ad;
    if (q > 8) q = lim + 1;
    else q = (an << WF) / ad;
    if (neg) return (q >= lim) ? -lim : -q;
    return (q >= lim) ? lim - 1 : q;
  endfunction

  function automatic weights_t predict_weights(logic signed [CW-1:0] px,
                                               logic signed [CW-1:0] py);
    weights_t r;
    longint det, mag, e0x, e0y, e1x, e1y, dx, dy, nu, nv, nw;
    e0x = longint'(bx) - ax;  e0y = longint'(by) - ay;
    e1x = longint'(cx) - ax;  e1y = longint'(cy) - ay;
    dx  = longint'(px) - ax;  dy  = longint'(py) - ay;
    det = e0x * e1y - e1x * e0y;
    mag = (det < 0) ? -det : det;
    r = '{in_tri: 1'b0, degen: 1'b0, u: '0, v: '0, w: '0};
    if (mag <= longint'(area_limit)) begin
      r.degen = 1'b1;
      return r;
    end
    nv = dx * e1y - e1x * dy;
    nw = e0x * dy - dx * e0y;
    nu = det - nv - nw;
    if (det > 0) r.in_tri = nv >= 0 && nw >= 0 && nu >= 0;
    else         r.in_tri = nv <= 0 && nw <= 0 && nu <= 0;
    r.u = scaled_ratio(nu, det);
    r.v = scaled_ratio(nv, det);
    r.w = scaled_ratio(nw, det);
    return r;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom % 100;
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(int c);
    if (c > 32767) return 16'sd32767;
    if (c < -32768) return -16'sd32768;
    return 16'(c);
  endfunction

  // Offer one point and wait for its transfer; called at a rising edge
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= px;
    pt.point_y <= py;
    do @(negedge clk); while (!pt.ready);
    @(posedge clk);
    pending_weights.push_back(predict_weights(px, py));
    points_sent++;
  endtask

  // Wait for every result plus the pipeline depth, leaving the block idle
  task automatic drain();
    pt.valid <= 1'b0;
    while (pending_weights.size() > 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic write_reg(tbi_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbi_pkg::REG_A_X:   ax = data[CW-1:0];
      tbi_pkg::REG_A_Y:   ay = data[CW-1:0];
      tbi_pkg::REG_B_X:   bx = data[CW-1:0];
      tbi_pkg::REG_B_Y:   by = data[CW-1:0];
      tbi_pkg::REG_C_X:   cx = data[CW-1:0];
      tbi_pkg::REG_C_Y:   cy = data[CW-1:0];
      tbi_pkg::REG_LIMIT: area_limit = data;
      default: ;
    endcase
  endtask

  task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2, logic [31:0] lim);
    drain();
    write_reg(tbi_pkg::REG_A_X, 32'(x0));
    write_reg(tbi_pkg::REG_A_Y, 32'(y0));
    write_reg(tbi_pkg::REG_B_X, 32'(x1));
    write_reg(tbi_pkg::REG_B_Y, 32'(y1));
    write_reg(tbi_pkg::REG_C_X, 32'(x2));
    write_reg(tbi_pkg::REG_C_Y, 32'(y2));
    write_reg(tbi_pkg::REG_LIMIT, lim);
  endtask

  // Vertices, edges, center, far points, both windings, degenerate cases, saturation
  task automatic test_directed();
    set_triangle(0, 0, 160, 0, 0, 160, 32'd0);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd160, 16'sd0);
    send_point(16'sd0, 16'sd160);
    send_point(16'sd80, 16'sd80);
    send_point(16'sd40, 16'sd40);
    send_point(16'sd161, 16'sd0);
    send_point(-16'sd1, 16'sd20);
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    // clockwise winding
    set_triangle(0, 0, 0, 160, 160, 0, 32'd0);
    send_point(16'sd80, 16'sd80);
    send_point(16'sd50, 16'sd50);
    send_point(16'sd100, 16'sd100);
    // largest triangle the coordinates allow
    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 32'd1000);
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(16'sd0, 16'sd0);
    // tiny triangle with far point: weights saturate
    set_triangle(0, 0, 1, 0, 0, 1, 32'd0);
    send_point(16'sd32767, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    // collinear vertices, and a limit equal to the area
    set_triangle(0, 0, 10, 10, 20, 20, 32'd0);
    send_point(16'sd10, 16'sd10);
    set_triangle(0, 0, 32, 0, 0, 32, 32'd1024);
    send_point(16'sd4, 16'sd4);
    set_triangle(0, 0, 32, 0, 0, 32, 32'd1023);
    send_point(16'sd4, 16'sd4);
    set_triangle(0, 0, 32, 0, 0, 32, 32'hFFFF_FFFF);
    send_point(16'sd4, 16'sd4);
  endtask

  // Random triangles, each with a burst of points mostly near the triangle
  task automatic test_random_triangles(int rounds, int per_round);
    int x[3], y[3], lo_x, hi_x, lo_y, hi_y, ctr_x, ctr_y, span, sel;
    longint mag;
    logic [31:0] lim;
    for (int r = 0; r < rounds; r++) begin
      sel   = $urandom % 4;
      span  = (sel == 0) ? 32767 : (sel == 1) ? 4000 : (sel == 2) ? 200 : 12;
      ctr_x = $urandom_range(0, 60000) - 30000;
      ctr_y = $urandom_range(0, 60000) - 30000;
      for (int k = 0; k < 3; k++) begin
        if (sel == 0) begin
          x[k] = $signed(16'($urandom));
          y[k] = $signed(16'($urandom));
        end else begin
          x[k] = clamp_coord(ctr_x + $urandom_range(0, 2 * span) - span);
          y[k] = clamp_coord(ctr_y + $urandom_range(0, 2 * span) - span);
        end
      end
      drain();
      write_reg(tbi_pkg::REG_A_X, 32'(x[0]));
      write_reg(tbi_pkg::REG_A_Y, 32'(y[0]));
      write_reg(tbi_pkg::REG_B_X, 32'(x[1]));
      write_reg(tbi_pkg::REG_B_Y, 32'(y[1]));
      write_reg(tbi_pkg::REG_C_X, 32'(x[2]));
      write_reg(tbi_pkg::REG_C_Y, 32'(y[2]));
      mag = area2();
      if (mag < 0) mag = -mag;
      case ($urandom % 8)
        0: lim = 32'hFFFF_FFFF;
        1: lim = (mag > 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : 32'(mag);
        2: lim = (mag == 0 || mag > 32'hFFFF_FFFF) ? 32'd0 : 32'(mag - 1);
        3: lim = $urandom;
        default: lim = $urandom_range(0, 3);
      endcase
      write_reg(tbi_pkg::REG_LIMIT, lim);
      lo_x = x[0]; hi_x = x[0]; lo_y = y[0]; hi_y = y[0];
      for (int k = 1; k < 3; k++) begin
        if (x[k] < lo_x) lo_x = x[k];
        if (x[k] > hi_x) hi_x = x[k];
        if (y[k] < lo_y) lo_y = y[k];
        if (y[k] > hi_y) hi_y = y[k];
      end
      no_idle = (r % 5 == 3);
      for (int i = 0; i < per_round; i++) begin
        if ($urandom % 8 == 0)
          send_point($signed(16'($urandom)), $signed(16'($urandom)));
        else
          send_point(clamp_coord(lo_x - 4 + $urandom_range(0, hi_x - lo_x + 8)),
                     clamp_coord(lo_y - 4 + $urandom_range(0, hi_y - lo_y + 8)));
      end
      no_idle = 1'b0;
    end
  endtask

  // Receiver holds off for a long stretch while points keep coming
  task automatic test_backpressure();
    set_triangle(-800, -800, 800, -600, 0, 900, 32'd0);
    hold_request = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 120; i++)
      send_point(clamp_coord($urandom_range(0, 2000) - 1000),
                 clamp_coord($urandom_range(0, 2000) - 1000));
    no_idle = 1'b0;
  endtask

  // Result-side ready, with random stalls and the long hold-off
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    res.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && !no_idle && $urandom % 150 == 0) begin
        stall_left = $urandom_range(10, 50);
      end
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= no_idle || ($urandom % 100 < 75);
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(negedge clk) begin
    weights_t exp_r;
    if (rst_n && res.valid && res.ready) begin
      results_seen++;
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result inside=%0b degen=%0b", $time,
                 res.inside_res, res.degenerate);
        error_count++;
      end else begin
        exp_r = pending_weights.pop_front();
        if (exp_r.degen) degen_seen++;
        if (exp_r.in_tri) inside_seen++;
        if (res.inside_res !== exp_r.in_tri) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, exp_r.in_tri,
                   res.inside_res);
          error_count++;
        end
        if (res.degenerate !== exp_r.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, exp_r.degen,
                   res.degenerate);
          error_count++;
        end
        if (res.weight_u !== exp_r.u) begin
          $display("%0t: weight_u expected %0d actual %0d", $time, exp_r.u, res.weight_u);
          error_count++;
        end
        if (res.weight_v !== exp_r.v) begin
          $display("%0t: weight_v expected %0d actual %0d", $time, exp_r.v, res.weight_v);
          error_count++;
        end
        if (res.weight_w !== exp_r.w) begin
          $display("%0t: weight_w expected %0d actual %0d", $time, exp_r.w, res.weight_w);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(negedge clk) begin
    if ((pt.valid && pt.ready) || (res.valid && res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("[triangle_barycentric_inside_test] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    {ax, ay, bx, by, cx, cy} = '0;
    area_limit = '0;
    error_count = 0;
    points_sent = 0;
    results_seen = 0;
    degen_seen = 0;
    inside_seen = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_triangles(9, 140);
    test_backpressure();
    drain();

    $display("Covered %0d points (%0d inside, %0d on degenerate triangles) over", points_sent,
             inside_seen, degen_seen);
    $display("directed corners, random triangles and a long result-side hold-off.");
    if (error_count == 0)
      $display("[triangle_barycentric_inside_test] OK");
    else
      $display("[triangle_barycentric_inside_test] ERROR");
    $finish;
  end

endmodule
